// File: rtl/core/huffman_tree_walk_decoder_top_macros.svh
// Assertion macros shared by the tree-walk decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/htwd_pkg.sv
// Shared constants, command codes and control/status types for the decoder.
// No dependencies; every file but the macro header imports it.
`timescale 1ns / 1ps

package htwd_pkg;

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 8;
  localparam int CHILD_W  = 9;
  localparam int SYM_W    = 8;
  localparam int BLKLEN_W = 24;
  localparam int BYTE_W   = 8;
  localparam int BIT_IDX_W = 3;

  localparam int TABLE_NODES_DEF  = 255;
  localparam int LENGTH_WIDTH_DEF = 24;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // write one node into the table
    logic start;  // set the length and return the walk to the root
    logic latch;  // capture a data byte
    logic fetch;  // read the node at the current walk position
    logic step;   // consume one bit
    logic flush;  // move the held symbol out, tagged last of run
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic left_zero;
    logic left_one;
    logic leaf;
    logic pend_valid;
    logic out_free;
    logic last_bit;
  } dp_status_t;

endpackage

// File: rtl/core/htwd_in_if.sv
// Input channel: command plus load, start and data payloads.
// Depends on htwd_pkg.
`timescale 1ns / 1ps

interface htwd_in_if;
  import htwd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [NODE_W-1:0]   node_index;
  logic [CHILD_W-1:0]  child_zero;
  logic [CHILD_W-1:0]  child_one;
  logic [BLKLEN_W-1:0] block_length;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, cmd, node_index, child_zero, child_one,
                  block_length, data_byte, input ready);
  modport sink (input valid, cmd, node_index, child_zero, child_one,
                block_length, data_byte, output ready);
endinterface

// File: rtl/core/htwd_out_if.sv
// Result channel: one decoded symbol per transfer with run and block flags.
// Depends on htwd_pkg.
`timescale 1ns / 1ps

interface htwd_out_if;
  import htwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_of_run;
  logic             block_end;

  modport source (output valid, symbol, last_of_run, block_end, input ready);
  modport sink (input valid, symbol, last_of_run, block_end, output ready);
endinterface

// File: rtl/core/htwd_ctrl.sv
// Sequencer for the tree walk: accepts commands and steps one bit per cycle unless a full output stalls it.
// Depends on htwd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_top_macros.svh"

module htwd_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [htwd_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_ready,
  input  htwd_pkg::dp_status_t      dp_st,
  output htwd_pkg::ctrl_cmd_t       cmd_o
);
  import htwd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_BIT   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_xfer;
  logic       stall;
  logic       done;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // Hold a leaf while the previous symbol cannot leave.
  assign stall    = dp_st.leaf && dp_st.pend_valid && !dp_st.out_free;
  assign done     = dp_st.last_bit || (dp_st.leaf && dp_st.left_one);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_cmd)
            CMD_LOAD:  cmd_o.load  = 1'b1;
            CMD_START: cmd_o.start = 1'b1;
            CMD_DATA: begin
              if (!dp_st.left_zero) begin
                cmd_o.latch = 1'b1;
                state_nxt   = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_nxt   = ST_BIT;
      end
      ST_BIT: begin
        if (!stall) begin
          cmd_o.step = 1'b1;
          if (done) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!dp_st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (dp_st.out_free) begin
          cmd_o.flush = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HTWD_ASSERT_IMPLY(a_flush_room, clk, rst_n, cmd_o.flush, dp_st.pend_valid && dp_st.out_free, "flush without pending symbol or output room")
  `HTWD_ASSERT_NEXT(a_done_flush, clk, rst_n, cmd_o.step && done, state_r == ST_FLUSH, "byte end did not reach flush")
  `HTWD_ASSERT_NEXT(a_stall_hold, clk, rst_n, state_r == ST_BIT && stall, state_r == ST_BIT, "walk left a stalled bit")

endmodule

// File: rtl/core/htwd_dp.sv
// Datapath: node table memory, walk position, symbol count, held symbol and
// output register. Depends on htwd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_top_macros.svh"

module htwd_dp #(
  parameter int TABLE_NODES  = htwd_pkg::TABLE_NODES_DEF,
  parameter int LENGTH_WIDTH = htwd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htwd_pkg::ctrl_cmd_t          cmd_i,
  output htwd_pkg::dp_status_t         dp_st,
  input  logic [htwd_pkg::NODE_W-1:0]   in_node_index,
  input  logic [htwd_pkg::CHILD_W-1:0]  in_child_zero,
  input  logic [htwd_pkg::CHILD_W-1:0]  in_child_one,
  input  logic [htwd_pkg::BLKLEN_W-1:0] in_block_length,
  input  logic [htwd_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [htwd_pkg::SYM_W-1:0]    out_symbol,
  output logic                         out_last_of_run,
  output logic                         out_block_end
);
  import htwd_pkg::*;

  localparam int ADDR_W = (TABLE_NODES > 1) ? $clog2(TABLE_NODES) : 1;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(TABLE_NODES - 1);
  localparam logic [NODE_W:0]   NODE_LIMIT = (NODE_W + 1)'(TABLE_NODES);

  logic [2*CHILD_W-1:0] mem [TABLE_NODES];

  logic [2*CHILD_W-1:0]  rd_data_r;
  logic                  oob_r;
  logic [NODE_W-1:0]     walk_r, walk_nxt;
  logic [LENGTH_WIDTH-1:0] left_r, left_nxt;
  logic [BYTE_W-1:0]     byte_r;
  logic [BIT_IDX_W-1:0]  bit_idx_r;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]      pend_sym_r;
  logic                  pend_end_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]      out_sym_r;
  logic                  out_last_r;
  logic                  out_end_r;

  logic [CHILD_W-1:0]    child;
  logic                  leaf;
  logic                  cur_bit;
  logic [NODE_W-1:0]     rd_node;
  logic                  rd_en;
  logic                  out_free;
  logic                  out_load;
  logic                  out_load_last;
  logic                  wr_ok;

  assign cur_bit = byte_r[bit_idx_r];
  // A pointer past the table reads as a node of two zero symbols.
  assign child   = oob_r ? '0 :
                   (cur_bit ? rd_data_r[2*CHILD_W-1:CHILD_W] : rd_data_r[CHILD_W-1:0]);
  assign leaf    = !child[CHILD_W-1];

  assign out_free      = !out_valid_r || out_ready;
  assign out_load      = (cmd_i.step && leaf && pend_valid_r) || cmd_i.flush;
  assign out_load_last = cmd_i.flush;

  assign rd_en   = cmd_i.fetch || cmd_i.step;
  assign rd_node = cmd_i.fetch ? walk_r : walk_nxt;
  assign wr_ok   = cmd_i.load && ({1'b0, in_node_index} < NODE_LIMIT);

  always_comb begin
    walk_nxt       = walk_r;
    left_nxt       = left_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd_i.start) begin
      walk_nxt = ROOT;
      left_nxt = LENGTH_WIDTH'(in_block_length);
    end else if (cmd_i.step) begin
      if (leaf) begin
        walk_nxt       = ROOT;
        left_nxt       = left_r - 1'b1;
        pend_valid_nxt = 1'b1;
      end else begin
        walk_nxt = child[NODE_W-1:0];
      end
    end else if (cmd_i.flush) begin
      pend_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_node_index[ADDR_W-1:0]] <= {in_child_one, in_child_zero};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_node[ADDR_W-1:0]];
      oob_r     <= ({1'b0, rd_node} >= NODE_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r       <= ROOT;
      left_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      walk_r       <= walk_nxt;
      left_r       <= left_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      byte_r    <= in_data_byte;
      bit_idx_r <= '0;
    end else if (cmd_i.step) begin
      bit_idx_r <= bit_idx_r + 1'b1;
    end
    if (cmd_i.step && leaf) begin
      pend_sym_r <= child[SYM_W-1:0];
      pend_end_r <= (left_r == LENGTH_WIDTH'(1));
    end
    if (out_load) begin
      out_sym_r  <= pend_sym_r;
      out_last_r <= out_load_last;
      out_end_r  <= pend_end_r;
    end
  end

  assign dp_st.left_zero  = (left_r == '0);
  assign dp_st.left_one   = (left_r == LENGTH_WIDTH'(1));
  assign dp_st.leaf       = leaf;
  assign dp_st.pend_valid = pend_valid_r;
  assign dp_st.out_free   = out_free;
  assign dp_st.last_bit   = (bit_idx_r == '1);

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_sym_r;
  assign out_last_of_run = out_last_r;
  assign out_block_end   = out_end_r;

  `HTWD_ASSERT_IMPLY(a_fetch_live, clk, rst_n, cmd_i.fetch, left_r != '0, "walk started with no symbols left")
  `HTWD_ASSERT_IMPLY(a_push_room, clk, rst_n, out_load, out_free, "symbol pushed into a full output register")
  `HTWD_ASSERT_NEXT(a_count_down, clk, rst_n, cmd_i.step && leaf, left_r == $past(left_r) - 1'b1, "leaf did not decrement the count")

endmodule

// File: rtl/core/huffman_tree_walk_decoder_top.sv
// Channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | cmd, node_index, child_zero, child_one, block_length, data_byte
// out_ch  | out | valid/ready | symbol, last_of_run, block_end
//
// Load, start and ignored commands leave the sequencer idle; so does a byte with no symbols left.
// A data byte with symbols left goes through accept, a node read, one bit per cycle through
// the node table unless a stall holds it, and a closing cycle that tags the last symbol.
// A block that ends mid-byte skips the remaining bits and goes straight to the closing cycle.
// A full output register stalls the walk at the next leaf and holds the closing cycle.
// Reset is synchronous, active low; the node table has no reset, the walk starts at the root.
// Top level of the tree-walk decoder; depends on htwd_pkg, both channel interfaces,
// htwd_ctrl and htwd_dp.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_top #(
  parameter int TABLE_NODES  = htwd_pkg::TABLE_NODES_DEF,
  parameter int LENGTH_WIDTH = htwd_pkg::LENGTH_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  htwd_in_if.sink    in_ch,
  htwd_out_if.source out_ch
);
  import htwd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  htwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .dp_st    (dp_st),
    .cmd_o    (cmd)
  );

  htwd_dp #(
    .TABLE_NODES  (TABLE_NODES),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .dp_st           (dp_st),
    .in_node_index   (in_ch.node_index),
    .in_child_zero   (in_ch.child_zero),
    .in_child_one    (in_ch.child_one),
    .in_block_length (in_ch.block_length),
    .in_data_byte    (in_ch.data_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_symbol      (out_ch.symbol),
    .out_last_of_run (out_ch.last_of_run),
    .out_block_end   (out_ch.block_end)
  );

endmodule
